### hw/rtl/varint_stream_decoder_macros.svh
`ifndef VARINT_STREAM_DECODER_MACROS_SVH
`define VARINT_STREAM_DECODER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define VSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vsd assertion failed");

// next-cycle implication
`define VSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vsd assertion failed");

`endif

### hw/rtl/vsd_pkg.sv
`timescale 1ns / 1ps

package vsd_pkg;

    localparam int unsigned GROUP_W     = 7;
    localparam int unsigned VALUE_W     = 64;
    localparam int unsigned IDX_W       = 4;
    localparam int unsigned SHAMT_W     = 6;
    localparam logic [3:0]  LIMIT_NARROW = 4'd5;
    localparam logic [3:0]  LIMIT_WIDE   = 4'd10;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_MANY = 2'd1,
        ST_ENDED    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ACT_CONT     = 2'd0,
        ACT_DONE     = 2'd1,
        ACT_TOO_MANY = 2'd2,
        ACT_ENDED    = 2'd3
    } action_t;

    typedef struct packed {
        logic [GROUP_W-1:0] group;
        logic [IDX_W-1:0]   idx;
        action_t            action;
        logic               wide;
    } entry_t;

endpackage

### hw/rtl/vsd_front.sv
`timescale 1ns / 1ps
`include "varint_stream_decoder_macros.svh"

module vsd_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic           cfg_wr_data,
    input  logic           accept,
    input  logic [7:0]     in_byte,
    input  logic           buffer_last,
    output vsd_pkg::entry_t entry
);
    import vsd_pkg::*;

    logic             wide_mode_reg;
    logic [IDX_W-1:0] byte_index_reg;
    logic [IDX_W-1:0] byte_index_next;
    logic [3:0]       limit;
    logic [IDX_W-1:0] idx_inc;
    action_t          action;

    assign limit   = wide_mode_reg ? LIMIT_WIDE : LIMIT_NARROW;
    assign idx_inc = byte_index_reg + 1'b1;

    always_comb
    begin
        if (!in_byte[7])
        begin
            action = ACT_DONE;
        end
        else if (idx_inc >= limit)
        begin
            action = ACT_TOO_MANY;
        end
        else if (buffer_last)
        begin
            action = ACT_ENDED;
        end
        else
        begin
            action = ACT_CONT;
        end
    end

    always_comb
    begin
        byte_index_next = byte_index_reg;
        if (accept)
        begin
            byte_index_next = (action == ACT_CONT) ? idx_inc : '0;
        end
    end

    assign entry.group  = in_byte[GROUP_W-1:0];
    assign entry.idx    = byte_index_reg;
    assign entry.action = action;
    assign entry.wide   = wide_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_mode_reg  <= 1'b0;
            byte_index_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                wide_mode_reg <= cfg_wr_data;
            end
            byte_index_reg <= byte_index_next;
        end
    end

    // byte index stops at the tenth byte of a varint
    `VSD_ASSERT_NOW(a_idx_range, 1'b1, byte_index_reg <= 4'd9)
    `VSD_ASSERT_NEXT(a_idx_restart, accept && (action != ACT_CONT), byte_index_reg == '0)

endmodule

### hw/rtl/vsd_fifo.sv
`timescale 1ns / 1ps
`include "varint_stream_decoder_macros.svh"

module vsd_fifo
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  vsd_pkg::entry_t wr_entry,
    input  logic            pop,
    output vsd_pkg::entry_t rd_entry,
    output logic            full,
    output logic            not_empty
);
    import vsd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    entry_t           slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign rd_entry  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + CNT_W'(1);
            2'b01:   cnt_next = cnt_reg - CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `VSD_ASSERT_NOW(a_no_underflow, !not_empty, !pop)
    `VSD_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(DEPTH))

endmodule

### hw/rtl/vsd_back.sv
`timescale 1ns / 1ps
`include "varint_stream_decoder_macros.svh"

module vsd_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  vsd_pkg::entry_t    head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] decoded_value,
    output logic [3:0]         bytes_used,
    output logic [1:0]         status
);
    import vsd_pkg::*;

    logic [VALUE_W-1:0] acc_reg;
    logic [VALUE_W-1:0] acc_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [VALUE_W-1:0] value_reg;
    logic [3:0]         bytes_reg;
    status_t            status_reg;

    logic [SHAMT_W-1:0] shamt;
    logic [VALUE_W-1:0] acc_or;
    logic [VALUE_W-1:0] ok_value;
    logic               terminal;
    logic               out_free;
    logic               emit;

    assign shamt    = SHAMT_W'({2'b00, head.idx} * 6'd7);
    assign acc_or   = acc_reg | ({{(VALUE_W - GROUP_W){1'b0}}, head.group} << shamt);
    assign ok_value = head.wide ? acc_or : {{32{acc_or[31]}}, acc_or[31:0]};

    assign terminal = (head.action != ACT_CONT);
    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = head_valid && (!terminal || out_free);
    assign emit     = pop && terminal;

    always_comb
    begin
        acc_next = acc_reg;
        if (pop)
        begin
            acc_next = terminal ? '0 : acc_or;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            case (head.action)
                ACT_DONE:
                begin
                    value_reg  <= ok_value;
                    bytes_reg  <= head.idx + 1'b1;
                    status_reg <= ST_OK;
                end
                ACT_TOO_MANY:
                begin
                    value_reg  <= '0;
                    bytes_reg  <= '0;
                    status_reg <= ST_TOO_MANY;
                end
                default:
                begin
                    value_reg  <= '0;
                    bytes_reg  <= '0;
                    status_reg <= ST_ENDED;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign decoded_value = value_reg;
    assign bytes_used    = bytes_reg;
    assign status        = status_reg;

    `VSD_ASSERT_NEXT(a_acc_cleared, emit, acc_reg == '0)
    `VSD_ASSERT_NOW(a_err_zero, out_valid_reg && (status_reg != ST_OK), (value_reg | bytes_reg) == '0)

endmodule

### hw/rtl/varint_stream_decoder.sv
`timescale 1ns / 1ps
// Unsigned LEB128 varint decoder, one encoded byte per input transaction.
// Input channel: in_valid / in_stall with in_byte and buffer_last (set on the
// final byte of a buffer). Output channel: out_valid / out_stall with
// decoded_value, bytes_used and status (0 ok, 1 too many bytes, 2 buffer
// ended mid-varint). A byte with bit 7 clear, or an error, yields one output
// transaction; continuation bytes yield none.
// Configuration: cfg_wr_en / cfg_wr_data set wide_mode (0 = 32-bit, up to 5
// bytes, sign-extended from bit 31; 1 = 64-bit, up to 10 bytes).
// Throughput: one byte per cycle, sustained while in_stall is low. The final
// byte of a varint passes through a queue slot, then the output register,
// before out_valid rises. The front end classifies each byte and tracks
// the byte count; a QUEUE_DEPTH entry queue feeds the back end, which owns
// the 64-bit accumulator and the output register.
// When out_stall is held, the output transaction holds, continuation bytes
// keep draining into the accumulator, and in_stall rises once the queue fills.
// Reset clears the accumulator, byte count, queue and wide_mode; no clearing
// pass is needed.

module varint_stream_decoder
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         in_byte,
    input  logic               buffer_last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] decoded_value,
    output logic [3:0]         bytes_used,
    output logic [1:0]         status
);
    import vsd_pkg::*;

    entry_t front_entry;
    entry_t head_entry;
    logic   accept;
    logic   q_full;
    logic   q_not_empty;
    logic   q_pop;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    vsd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .in_byte     (in_byte),
        .buffer_last (buffer_last),
        .entry       (front_entry)
    );

    vsd_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .wr_entry  (front_entry),
        .pop       (q_pop),
        .rd_entry  (head_entry),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    vsd_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (q_not_empty),
        .head          (head_entry),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .decoded_value (decoded_value),
        .bytes_used    (bytes_used),
        .status        (status)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import vsd_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 700;

    typedef struct packed {
        logic [63:0] value;
        logic [3:0]  used;
        status_t     status;
    } decode_t;

    typedef enum logic {
        ROW_BYTE,
        ROW_MODE
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  data;
        logic        last;
        logic        typed;
        decode_t     want;
    } stim_row_t;

    typedef enum logic [1:0] {
        SHAPE_FULL,
        SHAPE_CUT,
        SHAPE_LONG,
        SHAPE_NOISE
    } shape_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN,
        STALL_HEAVY
    } stall_style_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_wr_data = 1'b0;
    logic               in_valid = 1'b0;
    logic [7:0]         in_byte = 8'd0;
    logic               buffer_last = 1'b0;
    logic               out_stall = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic signed [63:0] decoded_value;
    logic [3:0]         bytes_used;
    logic [1:0]         status;

    decode_t      pending_q[$];
    logic [63:0]  acc_bits = '0;
    logic [3:0]   group_count = '0;
    logic         wide_sel = 1'b0;
    int           err_count = 0;
    int           sent_count = 0;
    int           burst_left = 0;
    int           idle_cycles = 0;
    int           style_left = 0;
    stall_style_t stall_style = STALL_NONE;

    varint_stream_decoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .buffer_last   (buffer_last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .decoded_value (decoded_value),
        .bytes_used    (bytes_used),
        .status        (status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit decode_byte(input logic [7:0] data, input logic last,
                                       output decode_t res);
        int          idx;
        int          limit;
        logic [63:0] v;
        idx = (group_count > 4'd9) ? 9 : int'(group_count);
        limit = wide_sel ? int'(LIMIT_WIDE) : int'(LIMIT_NARROW);
        acc_bits |= {57'd0, data[6:0]} << (idx * 7);
        res = '{64'd0, 4'd0, ST_OK};
        if (!data[7])
        begin
            v = wide_sel ? acc_bits : {{32{acc_bits[31]}}, acc_bits[31:0]};
            res = '{v, 4'(idx + 1), ST_OK};
        end
        else if (idx + 1 >= limit)
            res.status = ST_TOO_MANY;
        else if (last)
            res.status = ST_ENDED;
        else
        begin
            group_count = 4'(idx + 1);
            return 1'b0;
        end
        acc_bits = '0;
        group_count = '0;
        return 1'b1;
    endfunction

    function automatic stim_row_t byte_row(input logic [7:0] data, input logic last);
        return '{ROW_BYTE, data, last, 1'b0, '0};
    endfunction

    function automatic stim_row_t checked_row(input logic [7:0] data, input logic last,
                                              input decode_t want);
        return '{ROW_BYTE, data, last, 1'b1, want};
    endfunction

    function automatic stim_row_t mode_row(input logic mode);
        return '{ROW_MODE, {7'd0, mode}, 1'b0, 1'b0, '0};
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want_val);
        $display("%0t ns mismatch %s: got %h want %h", $time, what, got, want_val);
        err_count++;
    endtask

    task automatic send_byte(input logic [7:0] data, input logic last, input logic typed,
                             input decode_t want);
        decode_t res;
        bit      produced;
        in_valid <= 1'b1;
        in_byte <= data;
        buffer_last <= last;
        do
            @(posedge clk);
        while (in_stall);
        sent_count++;
        produced = decode_byte(data, last, res);
        if (produced)
            pending_q.push_back(typed ? want : res);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 20);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        wide_sel = mode;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_random_varint();
        int         span;
        int         limit;
        int         pick;
        int         k;
        shape_t     shape;
        logic [7:0] data;
        logic       last;
        logic       final_byte;
        limit = wide_sel ? int'(LIMIT_WIDE) : int'(LIMIT_NARROW);
        pick = $urandom_range(0, 9);
        shape = (pick < 7) ? SHAPE_FULL : (pick == 7) ? SHAPE_CUT
              : (pick == 8) ? SHAPE_LONG : SHAPE_NOISE;
        case (shape)
            SHAPE_FULL, SHAPE_CUT: span = $urandom_range(1, limit);
            SHAPE_LONG: span = limit;
            default: span = $urandom_range(1, 6);
        endcase
        for (k = 0; k < span; k++)
        begin
            data = 8'($urandom);
            last = ($urandom_range(0, 3) == 0);
            if (shape != SHAPE_NOISE)
            begin
                final_byte = (k == span - 1);
                data[7] = !(final_byte && shape == SHAPE_FULL);
                if (!final_byte)
                    last = 1'b0;
                else if (shape == SHAPE_CUT)
                    last = 1'b1;
            end
            send_byte(data, last, 1'b0, '0);
        end
    endtask

    // receiver back-pressure, own schedule
    always @(posedge clk)
    begin
        if (style_left == 0)
        begin
            stall_style <= stall_style_t'($urandom_range(0, 3));
            style_left <= $urandom_range(20, 200);
        end
        else
            style_left <= style_left - 1;
        case (stall_style)
            STALL_NONE: out_stall <= 1'b0;
            STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
            STALL_PATTERN: out_stall <= ((style_left % 5) < 2);
            default: out_stall <= ($urandom_range(0, 15) != 0);
        endcase
    end

    always @(posedge clk)
    begin : result_check
        decode_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
                report_mismatch("unexpected transaction", decoded_value, '0);
            else
            begin
                want = pending_q.pop_front();
                if (decoded_value !== want.value)
                    report_mismatch("decoded_value", decoded_value, want.value);
                if (bytes_used !== want.used)
                    report_mismatch("bytes_used", bytes_used, want.used);
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("varint_stream_decoder verification failed");
            $finish;
        end
    end

    initial
    begin
        stim_row_t directed_rows[$];
        int        random_end;
        int        target;
        int        phase;
        int        k;
        int        limit;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_rows = '{
            checked_row(8'h00, 1'b1, '{64'd0, 4'd1, ST_OK}),
            byte_row(8'hFF, 1'b0), byte_row(8'hFF, 1'b0),
            byte_row(8'hFF, 1'b0), byte_row(8'hFF, 1'b0),
            checked_row(8'h7F, 1'b0, '{64'hFFFF_FFFF_FFFF_FFFF, 4'd5, ST_OK}),
            byte_row(8'h80, 1'b0), byte_row(8'h80, 1'b0),
            byte_row(8'h80, 1'b0), byte_row(8'h80, 1'b0),
            checked_row(8'hFF, 1'b1, '{64'd0, 4'd0, ST_TOO_MANY}),
            checked_row(8'h81, 1'b1, '{64'd0, 4'd0, ST_ENDED}),
            mode_row(1'b1),
            byte_row(8'hFF, 1'b0), byte_row(8'hFF, 1'b0), byte_row(8'hFF, 1'b0),
            byte_row(8'hFF, 1'b0), byte_row(8'hFF, 1'b0), byte_row(8'hFF, 1'b0),
            byte_row(8'hFF, 1'b0), byte_row(8'hFF, 1'b0), byte_row(8'hFF, 1'b0),
            checked_row(8'h7F, 1'b1, '{64'hFFFF_FFFF_FFFF_FFFF, 4'd10, ST_OK}),
            byte_row(8'h81, 1'b0), byte_row(8'h81, 1'b0), byte_row(8'h81, 1'b0),
            byte_row(8'h81, 1'b0), byte_row(8'h81, 1'b0),
            mode_row(1'b0),
            byte_row(8'h00, 1'b0)
        };
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_MODE)
                write_mode(directed_rows[i].data[0]);
            else
                send_byte(directed_rows[i].data, directed_rows[i].last,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        random_end = sent_count + RANDOM_ITEMS;
        phase = 0;
        while (sent_count < random_end)
        begin
            write_mode((phase < 2) ? phase[0] : 1'($urandom_range(0, 1)));
            target = sent_count + $urandom_range(50, 120);
            while (sent_count < target)
            begin
                send_random_varint();
                if ($urandom_range(0, 59) == 0)
                    wait_drained();
            end
            // leave a varint open across the next mode write
            if ($urandom_range(0, 1) == 0)
            begin
                limit = wide_sel ? int'(LIMIT_WIDE) : int'(LIMIT_NARROW);
                for (k = 0; k < $urandom_range(1, limit - 1); k++)
                    send_byte(8'h80 | 8'($urandom_range(0, 127)), 1'b0, 1'b0, '0);
            end
            phase++;
        end

        wait_drained();
        if (err_count == 0)
            $display("varint_stream_decoder verification clean");
        else
            $display("varint_stream_decoder verification failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/vsd_pkg.sv
hw/rtl/vsd_front.sv
hw/rtl/vsd_fifo.sv
hw/rtl/vsd_back.sv
hw/rtl/varint_stream_decoder.sv
tb/testbench.sv
